// ===== design/acs_pkg.sv =====
// shared types and codes for the accumulator step unit
package acs_pkg;

	// item kinds
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	// instruction opcodes
	localparam logic [3:0] OP_NONE  = 4'd0;
	localparam logic [3:0] OP_LOAD  = 4'd1;
	localparam logic [3:0] OP_ADD   = 4'd2;
	localparam logic [3:0] OP_STORE = 4'd3;
	localparam logic [3:0] OP_SUB   = 4'd4;
	localparam logic [3:0] OP_IN    = 4'd5;
	localparam logic [3:0] OP_OUT   = 4'd6;
	localparam logic [3:0] OP_END   = 4'd7;
	localparam logic [3:0] OP_JMP   = 4'd8;
	localparam logic [3:0] OP_SKIPZ = 4'd9;

	// result status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_END    = 2'd1;
	localparam logic [1:0] ST_BADOP  = 2'd2;
	localparam logic [1:0] ST_HALTED = 2'd3;

	// program counter after reset
	localparam logic [9:0] START_RESET = 10'd10;

	typedef struct packed {
		logic               cmd;
		logic [9:0]         load_address;
		logic [3:0]         load_opcode;
		logic [9:0]         load_operand;
		logic signed [31:0] in_value;
	} cmd_word_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [9:0]         next_pc;
		logic signed [31:0] acc_value;
		logic               out_valid;
		logic signed [31:0] out_value;
	} rsp_word_t;

	typedef struct packed {
		logic [3:0] opcode;
		logic [9:0] operand;
	} prog_word_t;

endpackage

// ===== design/accumulator_cpu_step_unit.sv =====
// top level of the accumulator step unit: pipeline, program and data memories
// The unit takes one command word per clock once its clearing pass is done, unless rsp_stall
// holds the pipeline: after reset it zeroes all max(PROG_DEPTH, DATA_DEPTH) entries of both
// memories, with cmd_stall high; start address writes are taken during that time. A load word
// writes the program memory when accepted. A step word fetches its instruction from the
// program memory in the accept cycle, reads the data memory when it moves from stage 1 to
// stage 2, and updates the accumulator and the response register when it leaves stage 2.
// Stores are forwarded to a following load, and the accumulator of the
// instruction ahead is forwarded to a skip-if-zero, so steps can follow back to back.
// The longest path runs from the data memory read through the 32-bit add and zero test
// to the next program fetch address.
module accumulator_cpu_step_unit
	import acs_pkg::*;
#(
	parameter int PROG_DEPTH = 1024,
	parameter int DATA_DEPTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  cmd_word_t cmd_word,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_word_t rsp_word,
	input  logic      cfg_we,
	input  logic [9:0] cfg_data
);

	localparam int PA_W      = $clog2(PROG_DEPTH);
	localparam int DA_W      = $clog2(DATA_DEPTH);
	localparam int PCX_W     = (PA_W > 10) ? PA_W : 10;
	localparam int CLR_DEPTH = (PROG_DEPTH > DATA_DEPTH) ? PROG_DEPTH : DATA_DEPTH;
	localparam int CLR_W     = $clog2(CLR_DEPTH);

	// program address modulo depth, depth is at least 16
	function automatic logic [PA_W-1:0] prog_mod(input logic [9:0] a);
		logic [10:0] r;
		r = {1'b0, a};
		for (int k = 5; k >= 0; k--) begin
			if ((PROG_DEPTH << k) <= 1023 && r >= 11'(PROG_DEPTH << k)) begin
				r = r - 11'(PROG_DEPTH << k);
			end
		end
		return PA_W'(r);
	endfunction

	// data address modulo depth
	function automatic logic [DA_W-1:0] data_mod(input logic [9:0] a);
		logic [10:0] r;
		r = {1'b0, a};
		for (int k = 9; k >= 0; k--) begin
			if ((DATA_DEPTH << k) <= 1023 && r >= 11'(DATA_DEPTH << k)) begin
				r = r - 11'(DATA_DEPTH << k);
			end
		end
		return DA_W'(r);
	endfunction

	// program counter plus one with wrap
	function automatic logic [PA_W-1:0] pc_inc(input logic [PA_W-1:0] p);
		logic [PA_W:0] s;
		s = {1'b0, p} + (PA_W+1)'(1);
		return (s == (PA_W+1)'(PROG_DEPTH)) ? '0 : s[PA_W-1:0];
	endfunction

	// memories
	prog_word_t         prog_mem [PROG_DEPTH];
	logic signed [31:0] data_mem [DATA_DEPTH];

	// control state
	logic              clearing_q;
	logic [CLR_W-1:0]  clr_q;
	logic [PA_W-1:0]   pc_q;
	logic              halted_q;
	logic signed [31:0] acc_q;

	// stage 1: instruction word available
	logic               valid_s1;
	logic               cmd_s1;
	logic signed [31:0] in_value_s1;
	prog_word_t         word_s1;

	// stage 2: data word available
	logic               valid_s2;
	logic [3:0]         op_s2;
	logic [DA_W-1:0]    daddr_s2;
	logic signed [31:0] in_value_s2;
	logic [1:0]         status_s2;
	logic [PA_W-1:0]    pc_s2;
	logic signed [31:0] data_s2;
	logic               fwd_s2;
	logic signed [31:0] fwd_value_s2;

	// output register
	logic      rsp_valid_q;
	rsp_word_t rsp_q;

	// handshake and stage movement
	logic cmd_take;
	logic s1_go;
	logic s2_go;
	logic out_free;

	// stage 1 decode
	logic               exec_s1;
	logic [PA_W-1:0]    pc_one;
	logic [PA_W-1:0]    pc_two;
	logic [PA_W-1:0]    pc_after;
	logic               halted_after;
	logic [1:0]         status_s1;
	logic [DA_W-1:0]    daddr_s1;
	logic signed [31:0] acc_fwd;
	logic [PA_W-1:0]    fetch_addr;

	// stage 2 results
	logic signed [31:0] mem_value;
	logic signed [31:0] acc_new;
	logic               ov_s2;
	logic signed [31:0] oval_s2;
	logic [PCX_W-1:0]   pc_ext;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign s2_go     = valid_s2 && out_free;
	assign s1_go     = valid_s1 && (!valid_s2 || s2_go);
	assign cmd_stall = clearing_q || (valid_s1 && !s1_go);
	assign cmd_take  = cmd_valid && !cmd_stall;

	// accumulator seen by a skip in stage 1
	assign acc_fwd = valid_s2 ? acc_new : acc_q;

	// stage 1 control decode
	always_comb begin
		exec_s1      = valid_s1 && (cmd_s1 == CMD_STEP) && !halted_q;
		pc_one       = pc_inc(pc_q);
		pc_two       = pc_inc(pc_one);
		pc_after     = pc_q;
		halted_after = halted_q;
		status_s1    = halted_q ? ST_HALTED : ST_OK;
		if (exec_s1) begin
			case (word_s1.opcode)
				OP_LOAD, OP_ADD, OP_STORE, OP_SUB, OP_IN, OP_OUT: begin
					pc_after = pc_one;
				end
				OP_END: begin
					pc_after     = pc_one;
					halted_after = 1'b1;
					status_s1    = ST_END;
				end
				OP_JMP: begin
					pc_after = prog_mod(word_s1.operand);
				end
				OP_SKIPZ: begin
					pc_after = (acc_fwd == 32'sd0) ? pc_two : pc_one;
				end
				default: begin
					pc_after     = pc_one;
					halted_after = 1'b1;
					status_s1    = ST_BADOP;
				end
			endcase
		end
		daddr_s1 = data_mod(word_s1.operand);
	end

	// address for the fetch of an accepted step
	assign fetch_addr = (s1_go && exec_s1) ? pc_after : pc_q;

	// program memory: clear, load writes, step fetch
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			if ((CLR_W+1)'(clr_q) < (CLR_W+1)'(PROG_DEPTH)) begin
				prog_mem[clr_q[PA_W-1:0]] <= '0;
			end
		end else if (cmd_take && cmd_word.cmd == CMD_LOAD) begin
			prog_mem[prog_mod(cmd_word.load_address)] <= '{
				opcode:  cmd_word.load_opcode,
				operand: cmd_word.load_operand
			};
		end
		if (cmd_take && cmd_word.cmd == CMD_STEP) begin
			word_s1 <= prog_mem[fetch_addr];
		end
	end

	// data memory: clear, store writes, operand read
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			if ((CLR_W+1)'(clr_q) < (CLR_W+1)'(DATA_DEPTH)) begin
				data_mem[clr_q[DA_W-1:0]] <= '0;
			end
		end else if (s2_go && op_s2 == OP_STORE) begin
			data_mem[daddr_s2] <= acc_q;
		end
		if (s1_go) begin
			data_s2 <= data_mem[daddr_s1];
		end
	end

	// clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			clr_q <= clr_q + CLR_W'(1);
			if (clr_q == CLR_W'(CLR_DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q     <= PA_W'(START_RESET);
			halted_q <= 1'b0;
			acc_q    <= '0;
		end else begin
			if (cfg_we) begin
				pc_q <= prog_mod(cfg_data);
			end else if (s1_go) begin
				pc_q <= pc_after;
			end
			if (s1_go) begin
				halted_q <= halted_after;
			end
			if (s2_go) begin
				acc_q <= acc_new;
			end
		end
	end

	// pipeline valid bits and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd_take) begin
				valid_s1 <= 1'b1;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end
			if (s1_go) begin
				valid_s2 <= 1'b1;
			end else if (s2_go) begin
				valid_s2 <= 1'b0;
			end
			if (s2_go) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// stage payload registers
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			cmd_s1      <= cmd_word.cmd;
			in_value_s1 <= cmd_word.in_value;
		end
		if (s1_go) begin
			op_s2        <= exec_s1 ? word_s1.opcode : OP_NONE;
			daddr_s2     <= daddr_s1;
			in_value_s2  <= in_value_s1;
			status_s2    <= status_s1;
			pc_s2        <= pc_after;
			fwd_s2       <= s2_go && (op_s2 == OP_STORE) && (daddr_s2 == daddr_s1);
			fwd_value_s2 <= acc_q;
		end
		if (s2_go) begin
			rsp_q <= '{
				status:    status_s2,
				next_pc:   pc_ext[9:0],
				acc_value: acc_new,
				out_valid: ov_s2,
				out_value: oval_s2
			};
		end
	end

	// operand with store forwarding
	assign mem_value = fwd_s2 ? fwd_value_s2 : data_s2;
	assign pc_ext    = PCX_W'(pc_s2);

	acs_alu u_alu (
		.op        (op_s2),
		.acc       (acc_q),
		.mem_value (mem_value),
		.in_value  (in_value_s2),
		.acc_new   (acc_new),
		.out_valid (ov_s2),
		.out_value (oval_s2)
	);

	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_q;

endmodule

// ===== design/acs_alu.sv =====
// accumulator update for one executed instruction
module acs_alu
	import acs_pkg::*;
(
	input  logic [3:0]         op,
	input  logic signed [31:0] acc,
	input  logic signed [31:0] mem_value,
	input  logic signed [31:0] in_value,
	output logic signed [31:0] acc_new,
	output logic               out_valid,
	output logic signed [31:0] out_value
);

	// new accumulator, wraps modulo 2^32
	always_comb begin
		case (op)
			OP_LOAD: acc_new = mem_value;
			OP_ADD:  acc_new = acc + mem_value;
			OP_SUB:  acc_new = acc - mem_value;
			OP_IN:   acc_new = in_value;
			default: acc_new = acc;
		endcase
	end

	// report for out
	always_comb begin
		out_valid = (op == OP_OUT);
		out_value = (op == OP_OUT) ? acc : 32'sd0;
	end

endmodule
